// File: src/gbt_pkg.sv
// Shared types and constants for the gap buffer text store.
package gbt_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_MOVE   = 2'd2,
    ACT_DUMP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_DUMP
  } state_t;

  typedef struct packed {
    action_t          action;
    logic [7:0]       char_in;
    logic [CNT_W-1:0] position;
  } req_t;

  typedef struct packed {
    logic [7:0]       char_out;
    logic             char_valid;
    logic             last;
    logic [CNT_W-1:0] cursor;
    logic [CNT_W-1:0] text_length;
    logic             status;
  } rsp_t;

endpackage

// File: src/gbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/gap_buffer_text_store.sv
// Gap buffer text store: top level with action sequencer and result register.
//
// Usage:
//   Requests enter on req (req_valid/req_ready), one action each: insert,
//   delete before cursor, move cursor, or dump text. Results leave on rsp
//   (rsp_valid/rsp_ready) from a single output register.
//   Insert and delete results show in the cycle after the request is
//   accepted; a new request can follow every cycle while rsp is taken.
//   Move walks one byte per cycle across the gap through the single RAM
//   read/write port pair, then completes the last write and reports.
//   Dump reads one text entry per cycle while rsp is not stalled
//   (CAPACITY - gap size entries) and holds one found byte back so that the
//   final byte can carry last. req_ready is low for the whole of a move or
//   dump. A stall on rsp freezes a dump and holds back a move's report;
//   nothing is dropped.
//   Reset empties the text (cursor 0, length 0); RAM contents are left as
//   they are and are never read before being written.
module gap_buffer_text_store (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  gbt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output gbt_pkg::rsp_t rsp
);

  localparam logic [gbt_pkg::CNT_W-1:0] CAP_CNT = gbt_pkg::CNT_W'(gbt_pkg::CAPACITY);

  gbt_pkg::state_t state, state_next;
  logic [gbt_pkg::CNT_W-1:0]  gap_begin, gap_begin_next;
  logic [gbt_pkg::CNT_W-1:0]  gap_finish, gap_finish_next;
  logic [gbt_pkg::CNT_W-1:0]  tgt, tgt_next;
  logic [gbt_pkg::CNT_W-1:0]  idx, idx_next;
  logic                       pend_v, pend_v_next;
  logic [gbt_pkg::ADDR_W-1:0] pend_addr, pend_addr_next;
  logic                       rd_valid, rd_valid_next;
  logic [7:0]                 held, held_next;
  logic                       held_v, held_v_next;
  logic                       rsp_valid_next;
  gbt_pkg::rsp_t              rsp_next;

  logic                       ram_we, ram_re;
  logic [gbt_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]                 ram_wdata, ram_rdata;

  logic                       out_free, accept;
  logic [gbt_pkg::CNT_W-1:0]  text_len, idx_inc;
  logic                       emit, emit_valid, emit_last, emit_status;
  logic [7:0]                 emit_char;

  gbt_ram #(
    .WIDTH (8),
    .DEPTH (gbt_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == gbt_pkg::ST_IDLE) && out_free;
  assign accept    = req_valid && req_ready;
  assign text_len  = gbt_pkg::CNT_W'(gap_begin + CAP_CNT - gap_finish);
  assign idx_inc   = idx + 1'b1;

  // Hold state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gbt_pkg::ST_IDLE;
      gap_begin  <= '0;
      gap_finish <= CAP_CNT;
      pend_v     <= 1'b0;
      rd_valid   <= 1'b0;
      held_v     <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      gap_begin  <= gap_begin_next;
      gap_finish <= gap_finish_next;
      pend_v     <= pend_v_next;
      rd_valid   <= rd_valid_next;
      held_v     <= held_v_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tgt       <= tgt_next;
    idx       <= idx_next;
    pend_addr <= pend_addr_next;
    held      <= held_next;
    rsp       <= rsp_next;
  end

  // Sequence actions and drive the RAM
  always_comb begin
    state_next      = state;
    gap_begin_next  = gap_begin;
    gap_finish_next = gap_finish;
    tgt_next        = tgt;
    idx_next        = idx;
    pend_v_next     = pend_v;
    pend_addr_next  = pend_addr;
    rd_valid_next   = rd_valid;
    held_next       = held;
    held_v_next     = held_v;
    ram_we          = 1'b0;
    ram_waddr       = pend_addr;
    ram_wdata       = ram_rdata;
    ram_re          = 1'b0;
    ram_raddr       = idx[gbt_pkg::ADDR_W-1:0];
    emit            = 1'b0;
    emit_char       = '0;
    emit_valid      = 1'b0;
    emit_last       = 1'b1;
    emit_status     = 1'b0;

    unique case (state)
      gbt_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req.action)
            gbt_pkg::ACT_INSERT: begin
              emit = 1'b1;
              if (gap_begin != gap_finish) begin
                ram_we         = 1'b1;
                ram_waddr      = gap_begin[gbt_pkg::ADDR_W-1:0];
                ram_wdata      = req.char_in;
                gap_begin_next = gap_begin + 1'b1;
              end else begin
                emit_status = 1'b1;
              end
            end
            gbt_pkg::ACT_DELETE: begin
              emit = 1'b1;
              if (gap_begin != '0) begin
                gap_begin_next = gap_begin - 1'b1;
              end
            end
            gbt_pkg::ACT_MOVE: begin
              tgt_next    = (req.position > text_len) ? text_len : req.position;
              pend_v_next = 1'b0;
              state_next  = gbt_pkg::ST_MOVE;
            end
            default: begin
              idx_next      = (gap_begin == '0) ? gap_finish : '0;
              held_v_next   = 1'b0;
              rd_valid_next = 1'b0;
              state_next    = gbt_pkg::ST_DUMP;
            end
          endcase
        end
      end

      gbt_pkg::ST_MOVE: begin
        // Complete the write of the byte read last cycle
        if (pend_v) begin
          ram_we = 1'b1;
        end
        pend_v_next = 1'b0;
        if (gap_begin > tgt) begin
          ram_re          = 1'b1;
          ram_raddr       = gbt_pkg::ADDR_W'(gap_begin - 1'b1);
          pend_addr_next  = gbt_pkg::ADDR_W'(gap_finish - 1'b1);
          pend_v_next     = 1'b1;
          gap_begin_next  = gap_begin - 1'b1;
          gap_finish_next = gap_finish - 1'b1;
        end else if (gap_begin < tgt) begin
          ram_re          = 1'b1;
          ram_raddr       = gap_finish[gbt_pkg::ADDR_W-1:0];
          pend_addr_next  = gap_begin[gbt_pkg::ADDR_W-1:0];
          pend_v_next     = 1'b1;
          gap_begin_next  = gap_begin + 1'b1;
          gap_finish_next = gap_finish + 1'b1;
        end else if (!pend_v && out_free) begin
          emit       = 1'b1;
          state_next = gbt_pkg::ST_IDLE;
        end
      end

      default: begin
        // Advance the dump only when the result register can take a byte
        if (out_free) begin
          if (rd_valid && ram_rdata != '0) begin
            if (held_v) begin
              emit       = 1'b1;
              emit_char  = held;
              emit_valid = 1'b1;
              emit_last  = 1'b0;
            end
            held_next   = ram_rdata;
            held_v_next = 1'b1;
          end
          if (idx != CAP_CNT) begin
            ram_re        = 1'b1;
            rd_valid_next = 1'b1;
            idx_next      = (idx_inc == gap_begin) ? gap_finish : idx_inc;
          end else begin
            rd_valid_next = 1'b0;
            if (!rd_valid) begin
              emit       = 1'b1;
              emit_char  = held_v ? held : 8'd0;
              emit_valid = held_v;
              state_next = gbt_pkg::ST_IDLE;
            end
          end
        end
      end
    endcase

    // Load the result register
    rsp_valid_next = rsp_valid && !rsp_ready;
    rsp_next       = rsp;
    if (emit) begin
      rsp_valid_next       = 1'b1;
      rsp_next.char_out    = emit_char;
      rsp_next.char_valid  = emit_valid;
      rsp_next.last        = emit_last;
      rsp_next.cursor      = gap_begin_next;
      rsp_next.text_length = gbt_pkg::CNT_W'(gap_begin_next + CAP_CNT - gap_finish_next);
      rsp_next.status      = emit_status;
    end
  end

  // The gap never has negative size
  a_gap_order: assert property (@(posedge clk) disable iff (rst)
    gap_begin <= gap_finish)
    else $error("gap_begin passed gap_finish");

  // No move write is left pending once back in idle
  a_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == gbt_pkg::ST_IDLE |-> !pend_v)
    else $error("pending move write in idle");

  // Emitted text bytes are never zero
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.char_valid |-> rsp.char_out != 8'd0)
    else $error("zero byte emitted as text");

  // Insert into a full buffer reports full next cycle
  a_full: assert property (@(posedge clk) disable iff (rst)
    accept && req.action == gbt_pkg::ACT_INSERT && gap_begin == gap_finish
    |=> rsp_valid && rsp.status)
    else $error("full insert not reported");

  // The clamped move target never exceeds the text length
  a_move_tgt: assert property (@(posedge clk) disable iff (rst)
    state == gbt_pkg::ST_MOVE |-> tgt <= text_len)
    else $error("move target beyond text length");

endmodule

// File: dv/gap_buffer_text_store_tb.sv
// Self-checking testbench for the gap buffer text store: directed and random actions.
module gap_buffer_text_store_tb;

  localparam int CAPACITY = gbt_pkg::CAPACITY;
  localparam int CNT_W = gbt_pkg::CNT_W;
  localparam int RUN_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = CAPACITY + 16;

  // Predict the text and cursor after each action and hold the expected results
  class text_tracker;
    logic [7:0] text [CAPACITY];
    int gap_lo;
    int gap_hi;
    int fails;
    gbt_pkg::rsp_t pending_rsp[$];

    function new();
      gap_lo = 0;
      gap_hi = CAPACITY;
      fails = 0;
      foreach (text[i]) text[i] = 8'h00;
    endfunction

    function int text_len();
      return gap_lo + CAPACITY - gap_hi;
    endfunction

    function gbt_pkg::rsp_t make_rsp(logic [7:0] ch, logic valid, logic fin, logic stat);
      gbt_pkg::rsp_t r;
      r.char_out = ch;
      r.char_valid = valid;
      r.last = fin;
      r.cursor = CNT_W'(gap_lo);
      r.text_length = CNT_W'(text_len());
      r.status = stat;
      return r;
    endfunction

    // Apply one accepted request and queue the results it causes
    function void note_request(gbt_pkg::req_t r);
      int target;
      logic stat;
      logic [7:0] found[$];
      stat = 1'b0;
      case (r.action)
        gbt_pkg::ACT_INSERT: begin
          if (gap_lo >= gap_hi) begin
            stat = 1'b1;
          end else begin
            text[gap_lo] = r.char_in;
            gap_lo++;
          end
        end
        gbt_pkg::ACT_DELETE: begin
          if (gap_lo > 0) gap_lo--;
        end
        gbt_pkg::ACT_MOVE: begin
          target = r.position;
          if (target > text_len()) target = text_len();
          // walk bytes across the gap one at a time
          while (gap_lo > target) begin
            gap_lo--;
            gap_hi--;
            text[gap_hi] = text[gap_lo];
          end
          while (gap_lo < target) begin
            text[gap_lo] = text[gap_hi];
            gap_lo++;
            gap_hi++;
          end
        end
        default: begin
          // dump: skip the gap and zero bytes, mark the final byte
          for (int i = 0; i < CAPACITY; i++) begin
            if ((i < gap_lo || i >= gap_hi) && text[i] != 8'h00) found.push_back(text[i]);
          end
          if (found.size() == 0) begin
            pending_rsp.push_back(make_rsp(8'h00, 1'b0, 1'b1, 1'b0));
          end else begin
            foreach (found[k]) begin
              pending_rsp.push_back(make_rsp(found[k], 1'b1, k == found.size() - 1, 1'b0));
            end
          end
          return;
        end
      endcase
      pending_rsp.push_back(make_rsp(8'h00, 1'b0, 1'b1, stat));
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        fails++;
      end
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(gbt_pkg::rsp_t got);
      gbt_pkg::rsp_t want;
      if (pending_rsp.size() == 0) begin
        $error("result with nothing expected: char_out %0h cursor %0d length %0d",
               got.char_out, got.cursor, got.text_length);
        fails++;
        return;
      end
      want = pending_rsp.pop_front();
      check_field("char_out", want.char_out, got.char_out);
      check_field("char_valid", 8'(want.char_valid), 8'(got.char_valid));
      check_field("last", 8'(want.last), 8'(got.last));
      check_field("cursor", 8'(want.cursor), 8'(got.cursor));
      check_field("text_length", 8'(want.text_length), 8'(got.text_length));
      check_field("status", 8'(want.status), 8'(got.status));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  gbt_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready;
  gbt_pkg::rsp_t rsp;

  text_tracker tracker = new();
  bit calm = 1'b0;
  int rsp_hold = 0;
  int cycles = 0;

  gap_buffer_text_store dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // End the run as failed if it goes on past the run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Take results, stalling a random number of cycles after each one
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        tracker.check_result(rsp);
        rsp_hold = calm ? 0 : $urandom_range(0, 14);
      end
      if (rsp_hold > 0) begin
        rsp_ready <= 1'b0;
        rsp_hold--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Send one request after a random gap and wait until it is accepted
  task automatic send_action(gbt_pkg::action_t act, logic [7:0] ch, logic [CNT_W-1:0] pos);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{action: act, char_in: ch, position: pos};
    do @(posedge clk); while (!req_ready);
    tracker.note_request('{action: act, char_in: ch, position: pos});
  endtask

  task automatic send_random();
    logic [7:0] ch;
    ch = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom);
    send_action(gbt_pkg::ACT_INSERT, ch, CNT_W'($urandom));
  endtask

  initial begin
    int pick;
    int ins_weight;
    logic [CNT_W-1:0] pos;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty text, delete at start, clamped moves, edge bytes, zero bytes
    send_action(gbt_pkg::ACT_DUMP, 8'($urandom), CNT_W'($urandom));
    send_action(gbt_pkg::ACT_DELETE, 8'($urandom), CNT_W'($urandom));
    send_action(gbt_pkg::ACT_MOVE, 8'($urandom), 7'd127);
    send_action(gbt_pkg::ACT_INSERT, 8'hFF, CNT_W'($urandom));
    send_action(gbt_pkg::ACT_INSERT, 8'h00, CNT_W'($urandom));
    send_action(gbt_pkg::ACT_INSERT, 8'h01, CNT_W'($urandom));
    send_action(gbt_pkg::ACT_INSERT, 8'h80, CNT_W'($urandom));
    send_action(gbt_pkg::ACT_DUMP, 8'($urandom), CNT_W'($urandom));
    send_action(gbt_pkg::ACT_MOVE, 8'($urandom), 7'd0);
    send_action(gbt_pkg::ACT_INSERT, 8'h7F, CNT_W'($urandom));
    send_action(gbt_pkg::ACT_MOVE, 8'($urandom), 7'd2);
    send_action(gbt_pkg::ACT_DELETE, 8'($urandom), CNT_W'($urandom));
    send_action(gbt_pkg::ACT_MOVE, 8'($urandom), 7'd64);
    send_action(gbt_pkg::ACT_MOVE, 8'($urandom), 7'd127);
    send_action(gbt_pkg::ACT_DUMP, 8'($urandom), CNT_W'($urandom));
    send_action(gbt_pkg::ACT_MOVE, 8'($urandom), 7'd1);
    send_action(gbt_pkg::ACT_INSERT, 8'h00, CNT_W'($urandom));
    send_action(gbt_pkg::ACT_DELETE, 8'($urandom), CNT_W'($urandom));
    send_action(gbt_pkg::ACT_DUMP, 8'($urandom), CNT_W'($urandom));

    // Random: text grows early, is filled past capacity once, then shrinks
    for (int k = 0; k < 40; k++) begin
      if (k % 10 == 0) calm = ($urandom_range(0, 2) == 0);
      if (k == 15) begin
        while (tracker.text_len() < CAPACITY) send_random();
        repeat (3) send_random();
        send_action(gbt_pkg::ACT_DUMP, 8'($urandom), CNT_W'($urandom));
        send_action(gbt_pkg::ACT_MOVE, 8'($urandom), CNT_W'($urandom_range(0, CAPACITY)));
        send_random();
        send_action(gbt_pkg::ACT_DUMP, 8'($urandom), CNT_W'($urandom));
      end
      ins_weight = (k < 27) ? 45 : 20;
      pick = $urandom_range(0, 99);
      if (pick < ins_weight) begin
        send_random();
      end else if (pick < 60) begin
        send_action(gbt_pkg::ACT_DELETE, 8'($urandom), CNT_W'($urandom));
      end else if (pick < 85) begin
        if ($urandom_range(0, 9) < 7) pos = CNT_W'($urandom_range(0, tracker.text_len()));
        else pos = CNT_W'($urandom);
        send_action(gbt_pkg::ACT_MOVE, 8'($urandom), pos);
      end else begin
        send_action(gbt_pkg::ACT_DUMP, 8'($urandom), CNT_W'($urandom));
      end
    end
    req_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (tracker.pending_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/gbt_pkg.sv
src/gbt_ram.sv
src/gap_buffer_text_store.sv
dv/gap_buffer_text_store_tb.sv
